### rtl/saa_pkg.sv
// shared constants, types and a helper function for the segregated allocator
`timescale 1ns / 1ps
package saa_pkg;

	localparam int unsigned HEAP_BYTES   = 1048576;
	localparam int unsigned SIZE_CLASSES = 32;
	localparam int unsigned HEADER_BYTES = 8;

	localparam int unsigned ADDR_W     = 20;
	localparam int unsigned WORD_W     = 21;
	localparam int unsigned REQ_W      = 21;
	localparam int unsigned CLS_W      = 5;
	localparam int unsigned SPAN_W     = 5;
	localparam int unsigned HEAP_WORDS = HEAP_BYTES / 8;
	localparam int unsigned WIDX_W     = $clog2(HEAP_WORDS);
	localparam int unsigned RESERVED   = SIZE_CLASSES * HEADER_BYTES;
	localparam int unsigned SPAN_RESET = 5;

	// controller to datapath commands
	typedef struct packed {
		logic in_load;
		logic dec;
		logic pop;
		logic split;
		logic brk;
		logic fpush;
		logic fail;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_free;
		logic start_ok;
		logic hit;
		logic fit;
		logic need_split;
		logic split_last;
	} status_t;

	// smallest t with 2^t >= x, zero for x <= 1
	function automatic logic [CLS_W-1:0] class_of(input logic [REQ_W:0] x);
		logic [REQ_W:0] xm;
		logic [CLS_W-1:0] t;
		xm = x - 1'b1;
		t = '0;
		for (int b = 0; b <= int'(REQ_W); b++) begin
			if (xm[b]) begin
				t = CLS_W'(b + 1);
			end
		end
		if (x <= 1) begin
			t = '0;
		end
		return t;
	endfunction

endpackage

### rtl/power_of_two_segregated_allocator.sv
// top level of the power-of-two segregated free-list allocator
//
// channel   direction  tdata                                 tuser
// s_axis    in         [20:0] request_bytes, [40:21] block   [0] command
//                      _address, [47:41] zero
// m_axis    out        [19:0] result_address, [23:20] zero   [0] success
// config    in         search_span_wdata, taken when search_span_we is high
//
// an allocate from its own list steps through decode, pop and done; when a larger list is split,
// the split state repeats for each split piece; a break pointer allocate or a failure steps through
// decode and done; a free steps through decode, push and done; the input is ready again as the result becomes valid
// the split loop handles one piece per cycle; the heap memory read is registered
// one item at a time; a finished result waits in the output register
// reset empties every list and puts the break pointer at 256, heap memory is not cleared
`timescale 1ns / 1ps
module power_of_two_segregated_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [47:0]                   s_axis_tdata,  // request_bytes, block_address
	input  logic [0:0]                    s_axis_tuser,  // command
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [23:0]                   m_axis_tdata,  // result_address
	output logic [0:0]                    m_axis_tuser,  // success
	input  logic                          search_span_we,
	input  logic [saa_pkg::SPAN_W-1:0]    search_span_wdata
);

	saa_pkg::cmd_t    cmd;
	saa_pkg::status_t st;
	logic [saa_pkg::ADDR_W-1:0] result_address;
	logic                       success;

	// sequencing
	saa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	// storage and arithmetic
	saa_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.in_command         (s_axis_tuser[0]),
		.in_request_bytes   (s_axis_tdata[20:0]),
		.in_block_address   (s_axis_tdata[40:21]),
		.span_we            (search_span_we),
		.span_wdata         (search_span_wdata),
		.out_result_address (result_address),
		.out_success        (success)
	);

	// result packing
	assign m_axis_tdata = {4'b0000, result_address};
	assign m_axis_tuser = success;

endmodule

### rtl/saa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module saa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/saa_ctrl.sv
// controller state machine sequencing allocate and free operations
`timescale 1ns / 1ps
module saa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  saa_pkg::status_t st,
	output saa_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_POP   = 3'd2;
	localparam logic [2:0] S_SPLIT = 3'd3;
	localparam logic [2:0] S_FPUSH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ovalid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (st.is_free) begin
					if (st.start_ok) begin
						cmd.dec = 1'b1;
						state_d = S_FPUSH;
					end else begin
						cmd.fail = 1'b1;
						state_d = S_DONE;
					end
				end else if (st.hit) begin
					cmd.dec = 1'b1;
					state_d = S_POP;
				end else if (st.fit) begin
					cmd.brk = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.fail = 1'b1;
					state_d = S_DONE;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = st.need_split ? S_SPLIT : S_DONE;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				if (st.split_last) begin
					state_d = S_DONE;
				end
			end
			S_FPUSH: begin
				cmd.fpush = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!ovalid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/saa_dp.sv
// datapath: list heads, break pointer, heap memory and result registers
`timescale 1ns / 1ps
module saa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  saa_pkg::cmd_t                      cmd,
	output saa_pkg::status_t                   st,
	input  logic                               in_command,
	input  logic [saa_pkg::REQ_W-1:0]          in_request_bytes,
	input  logic [saa_pkg::ADDR_W-1:0]         in_block_address,
	input  logic                               span_we,
	input  logic [saa_pkg::SPAN_W-1:0]         span_wdata,
	output logic [saa_pkg::ADDR_W-1:0]         out_result_address,
	output logic                               out_success
);

	localparam int unsigned AW = saa_pkg::ADDR_W;
	localparam int unsigned WW = saa_pkg::WORD_W;
	localparam int unsigned CW = saa_pkg::CLS_W;
	localparam int unsigned NC = saa_pkg::SIZE_CLASSES;

	logic                    cmd_q;
	logic [saa_pkg::REQ_W-1:0] req_q;
	logic [AW-1:0]           baddr_q;
	logic [saa_pkg::SPAN_W-1:0] span_q;
	logic [AW-1:0]           head_q [NC];
	logic [WW-1:0]           bp_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [AW-1:0]           res_q;
	logic [AW-1:0]           addr_q;
	logic                    ok_q;

	logic [saa_pkg::REQ_W:0] rounded;
	logic [CW-1:0]           k;
	logic [WW-1:0]           hdr_w;
	logic [WW:0]             blk;
	logic [AW-1:0]           start;
	logic [NC-1:0]           ne;
	logic [CW:0]             top_w;
	logic [CW-1:0]           top;
	logic                    found_any;
	logic [CW-1:0]           found_idx;
	logic [CW-1:0]           i_sel;
	logic [CW-1:0]           rd_idx;
	logic [AW-1:0]           head_rd;
	logic [CW-1:0]           cls_f;
	logic [AW-1:0]           piece;
	logic                    piece_ok;
	logic                    ram_we;
	logic [saa_pkg::WIDX_W-1:0] ram_waddr;
	logic [WW-1:0]           ram_wdata;
	logic [saa_pkg::WIDX_W-1:0] ram_raddr;
	logic [WW-1:0]           ram_rdata;
	logic [WW+1:0]           bp_end;

	// size class of the request
	assign rounded = ({1'b0, req_q} + (saa_pkg::REQ_W + 1)'(saa_pkg::HEADER_BYTES + 7))
		& ~(saa_pkg::REQ_W + 1)'(7);
	assign k       = saa_pkg::class_of(rounded);
	assign hdr_w   = WW'(1) << k;
	assign blk     = (WW + 1)'(1) << k;
	assign start   = baddr_q - AW'(saa_pkg::HEADER_BYTES);

	// search window over larger classes
	assign top_w = {1'b0, k} + {1'b0, span_q};
	assign top   = (top_w > (CW + 1)'(NC - 1)) ? CW'(NC - 1) : top_w[CW-1:0];

	always_comb begin
		found_any = 1'b0;
		found_idx = '0;
		for (int c = NC - 1; c >= 0; c--) begin
			ne[c] = (head_q[c] != '0);
			if (ne[c] && (CW'(c) > k) && (CW'(c) <= top)) begin
				found_any = 1'b1;
				found_idx = CW'(c);
			end
		end
	end

	assign i_sel   = ne[k] ? k : found_idx;
	assign cls_f   = saa_pkg::class_of({1'b0, ram_rdata});
	assign rd_idx  = cmd.dec ? i_sel : (cmd.split ? j_q : cls_f);
	assign head_rd = head_q[rd_idx];

	// split piece address, wrapping in the heap
	assign piece    = res_q + (AW'(1) << j_q);
	assign piece_ok = (piece >= AW'(saa_pkg::RESERVED));

	assign bp_end = {2'b00, bp_q} + {1'b0, blk};

	// status back to the controller, a class above the word width never fits
	assign st.is_free    = cmd_q;
	assign st.start_ok   = (start >= AW'(saa_pkg::RESERVED));
	assign st.hit        = ne[k] | found_any;
	assign st.fit        = (k <= CW'(WW)) && (bp_end <= (WW + 2)'(saa_pkg::HEAP_BYTES));
	assign st.need_split = (i_q != k);
	assign st.split_last = (j_q == (i_q - 1'b1));

	// heap memory port selection
	assign ram_raddr = cmd_q ? start[AW-1:3] : head_rd[AW-1:3];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = res_q[AW-1:3];
		ram_wdata = hdr_w;
		if (cmd.pop) begin
			ram_we = 1'b1;
		end else if (cmd.split) begin
			ram_we    = piece_ok;
			ram_waddr = piece[AW-1:3];
			ram_wdata = {1'b0, head_rd};
		end else if (cmd.brk) begin
			ram_we    = 1'b1;
			ram_waddr = bp_q[AW-1:3];
		end else if (cmd.fpush) begin
			ram_we    = 1'b1;
			ram_waddr = start[AW-1:3];
			ram_wdata = {1'b0, head_rd};
		end
	end

	saa_ram #(
		.WIDTH(saa_pkg::WORD_W),
		.DEPTH(saa_pkg::HEAP_WORDS)
	) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state: list heads, break pointer, span register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				head_q[c] <= '0;
			end
			bp_q   <= WW'(saa_pkg::RESERVED);
			span_q <= saa_pkg::SPAN_W'(saa_pkg::SPAN_RESET);
		end else begin
			if (span_we) begin
				span_q <= span_wdata;
			end
			if (cmd.pop) begin
				head_q[i_q] <= ram_rdata[AW-1:0];
			end else if (cmd.split && piece_ok) begin
				head_q[j_q] <= piece;
			end else if (cmd.fpush) begin
				head_q[cls_f] <= start;
			end
			if (cmd.brk) begin
				bp_q <= bp_end[WW-1:0];
			end
		end
	end

	// operands, counters and results
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			cmd_q   <= in_command;
			req_q   <= in_request_bytes;
			baddr_q <= in_block_address;
		end
		if (cmd.dec) begin
			i_q   <= i_sel;
			res_q <= head_rd;
		end
		if (cmd.pop) begin
			j_q    <= k;
			addr_q <= res_q + AW'(saa_pkg::HEADER_BYTES);
			ok_q   <= 1'b1;
		end else if (cmd.split) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.brk) begin
			addr_q <= bp_q[AW-1:0] + AW'(saa_pkg::HEADER_BYTES);
			ok_q   <= 1'b1;
		end else if (cmd.fpush) begin
			addr_q <= '0;
			ok_q   <= 1'b1;
		end else if (cmd.fail) begin
			addr_q <= '0;
			ok_q   <= 1'b0;
		end
		if (cmd.out_load) begin
			out_result_address <= addr_q;
			out_success        <= ok_q;
		end
	end

endmodule
